/* sv/ccbl_pkg.sv */
// Shared types and constants for the cubical cell birth lookup block.
// Holds item mode codes, register indexes, sequencer states, neighbor offsets
// and the spanned-axis decode. No dependencies.
package ccbl_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_BIRTH  = 2'd1,
    MODE_PARENT = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    CFG_GRID_DIMS = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  localparam int CFG_DATA_W  = 32;
  localparam int RESULT_W    = 32;
  localparam int COORD_W     = 4;
  localparam int SCAN_IDX_W  = 4;

  // Neighbor offsets for the parent search; bit set means offset -1 on that
  // axis (bit0 x, bit1 y, bit2 z), clear means offset 0.
  localparam logic [2:0] PARENT_OFFSETS [8] = '{
    3'b000, 3'b001, 3'b011, 3'b111, 3'b101, 3'b010, 3'b110, 3'b100
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] mask;
  } span_t;

  // Spanned-axis mask for a cell, with ok cleared for an invalid cell.
  function automatic span_t span_decode(input logic four, input logic [2:0] d,
                                        input logic [2:0] cm);
    span_t s;
    s.ok   = 1'b1;
    s.mask = 4'h0;
    if (!four) begin
      case (d)
        3'd3: s.mask = 4'h7;
        3'd0: s.mask = 4'h0;
        3'd2: begin
          case (cm)
            3'd0: s.mask = 4'h3;
            3'd1: s.mask = 4'h5;
            3'd2: s.mask = 4'h6;
            default: s.ok = 1'b0;
          endcase
        end
        3'd1: begin
          case (cm)
            3'd0: s.mask = 4'h1;
            3'd1: s.mask = 4'h2;
            3'd2: s.mask = 4'h4;
            default: s.ok = 1'b0;
          endcase
        end
        default: s.ok = 1'b0;
      endcase
    end else begin
      case (d)
        3'd4: s.mask = 4'hF;
        3'd0: s.mask = 4'h0;
        3'd3: begin
          case (cm)
            3'd0: s.mask = 4'h7;
            3'd1: s.mask = 4'hB;
            3'd2: s.mask = 4'hD;
            3'd3: s.mask = 4'hE;
            default: s.ok = 1'b0;
          endcase
        end
        3'd2: begin
          case (cm)
            3'd0: s.mask = 4'h3;
            3'd1: s.mask = 4'h5;
            3'd2: s.mask = 4'h6;
            3'd3: s.mask = 4'h9;
            3'd4: s.mask = 4'hA;
            3'd5: s.mask = 4'hC;
            default: s.ok = 1'b0;
          endcase
        end
        3'd1: begin
          case (cm)
            3'd0: s.mask = 4'h1;
            3'd1: s.mask = 4'h2;
            3'd2: s.mask = 4'h4;
            3'd3: s.mask = 4'h8;
            default: s.ok = 1'b0;
          endcase
        end
        default: s.ok = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

/* sv/ccbl_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on ccbl_pkg for the mode type.
interface ccbl_in_if;
  logic              valid;
  logic              ready;
  ccbl_pkg::mode_t   mode;
  logic [3:0]        coord_x;
  logic [3:0]        coord_y;
  logic [3:0]        coord_z;
  logic [3:0]        coord_w;
  logic [2:0]        cell_dim;
  logic [2:0]        orientation;
  logic signed [31:0] data_value;

  modport source (output valid, mode, coord_x, coord_y, coord_z, coord_w,
                  cell_dim, orientation, data_value, input ready);
  modport sink (input valid, mode, coord_x, coord_y, coord_z, coord_w,
                cell_dim, orientation, data_value, output ready);
endinterface

interface ccbl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] birth_value;
  logic [3:0]         parent_x;
  logic [3:0]         parent_y;
  logic [3:0]         parent_z;
  logic [3:0]         parent_w;
  logic               parent_found;

  modport source (output valid, birth_value, parent_x, parent_y, parent_z,
                  parent_w, parent_found, input ready);
  modport sink (input valid, birth_value, parent_x, parent_y, parent_z,
                parent_w, parent_found, output ready);
endinterface

/* sv/cubical_cell_birth_lookup_top.sv */
// Cubical cell birth lookup: voxel store, birth minimum and parent search (ccbl_pkg, ccbl_if).
// Birth and parent queries scan the voxel memory; a write, a no-op beat or an invalid-cell
// birth query skips the scan. A new item is taken only in idle, after the last result is loaded;
// scans are paced by the single-port voxel memory: one read per cycle over 8 or 16 scan positions.
// Reset (rst, synchronous, active high) clears control and config; voxel memory
// is not cleared and holds garbage until written.
module cubical_cell_birth_lookup_top #(
  parameter int GRID_EDGE   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  ccbl_pkg::cfg_idx_t             cfg_index,
  input  logic [ccbl_pkg::CFG_DATA_W-1:0] cfg_data,
  ccbl_in_if.sink                        item,
  ccbl_out_if.source                     result
);

  localparam int CW = $clog2(GRID_EDGE);
  localparam int WW = CW + 5;
  localparam int AW = 4 * CW;
  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam longint unsigned DEPTH = 64'd1 << AW;

  // Coordinate helpers: reduce a 4-bit index mod edge, step +1/-1 with wrap.
  function automatic logic [CW-1:0] wrap_in(input logic [3:0] v);
    logic [WW-1:0] r;
    r = WW'(v);
    for (int i = 0; i < 4; i++) begin
      if (r >= WW'(GRID_EDGE)) r = r - WW'(GRID_EDGE);
    end
    return r[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] inc_wrap(input logic [CW-1:0] v);
    return (v == CW'(GRID_EDGE - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [CW-1:0] dec_wrap(input logic [CW-1:0] v);
    return (v == '0) ? CW'(GRID_EDGE - 1) : v - 1'b1;
  endfunction

  function automatic logic [3:0] to_port(input logic [CW-1:0] v);
    logic [CW+3:0] t;
    t = {4'b0000, v};
    return t[3:0];
  endfunction

  // Configuration registers.
  logic [2:0]         grid_dims;
  logic signed [31:0] threshold_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dims       <= 3'd3;
      threshold_value <= 32'sh7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccbl_pkg::CFG_GRID_DIMS: grid_dims       <= cfg_data[2:0];
        ccbl_pkg::CFG_THRESHOLD: threshold_value <= cfg_data;
      endcase
    end
  end

  wire four = (grid_dims >= 3'd4);

  // Sequencer and per-item context.
  ccbl_pkg::state_t  state;
  ccbl_pkg::mode_t   mode_q;
  logic              four_q;
  logic [CW-1:0]     cx, cy, cz, cw;
  logic [3:0]        span_q;
  logic              span_ok_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [ccbl_pkg::SCAN_IDX_W-1:0] cnt;
  logic [ccbl_pkg::SCAN_IDX_W-1:0] pend_idx;
  logic              pend;
  logic              first;
  logic signed [VALUE_WIDTH-1:0] best;
  logic              found;
  logic [CW-1:0]     px, py, pz, pw;

  wire accept = item.valid && item.ready;
  assign item.ready = (state == ccbl_pkg::ST_IDLE);

  ccbl_pkg::span_t span_in;
  assign span_in = ccbl_pkg::span_decode(four, item.cell_dim, item.orientation);

  // Normalize the incoming value: keep the low bits, sign-extend to store width.
  logic [VALUE_WIDTH+SW-1:0] val_ext;
  assign val_ext = {{VALUE_WIDTH{item.data_value[SW-1]}}, item.data_value[SW-1:0]};

  logic [CW-1:0] in_x, in_y, in_z, in_w;
  assign in_x = wrap_in(item.coord_x);
  assign in_y = wrap_in(item.coord_y);
  assign in_z = wrap_in(item.coord_z);
  assign in_w = four ? wrap_in(item.coord_w) : '0;

  // Scan address for the current position.
  logic [2:0]    off;
  logic          issue_ok;
  logic [CW-1:0] sx, sy, sz, sw;
  wire  [ccbl_pkg::SCAN_IDX_W-1:0] last = four_q ? 4'hF : 4'h7;

  always_comb begin
    off = ccbl_pkg::PARENT_OFFSETS[cnt[2:0]];
    if (mode_q == ccbl_pkg::MODE_BIRTH) begin
      // Spanned axes sit at +1; free axes follow the position bit.
      issue_ok = ((cnt & span_q) == span_q);
      sx = (span_q[0] | cnt[0]) ? inc_wrap(cx) : cx;
      sy = (span_q[1] | cnt[1]) ? inc_wrap(cy) : cy;
      sz = (span_q[2] | cnt[2]) ? inc_wrap(cz) : cz;
      sw = (span_q[3] | cnt[3]) ? inc_wrap(cw) : cw;
    end else begin
      // Voxel at cube + 1 + offset: offset -1 lands on the cube coordinate.
      issue_ok = !found;
      sx = off[0] ? cx : inc_wrap(cx);
      sy = off[1] ? cy : inc_wrap(cy);
      sz = off[2] ? cz : inc_wrap(cz);
      sw = four_q ? (cnt[3] ? cw : inc_wrap(cw)) : '0;
    end
  end

  // Single-port voxel memory with registered read.
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;

  assign mem_we   = accept && (item.mode == ccbl_pkg::MODE_WRITE);
  assign mem_addr = mem_we ? {in_w, in_z, in_y, in_x} : {sw, sz, sy, sx};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= val_ext[VALUE_WIDTH-1:0];
    rd_data <= mem[mem_addr];
  end

  // Shared compare unit: signed less-than for birth, equality for parent.
  wire hit_less  = ($signed(rd_data) < best);
  wire hit_equal = (rd_data == val_q);
  logic [2:0] poff;
  assign poff = ccbl_pkg::PARENT_OFFSETS[pend_idx[2:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccbl_pkg::ST_IDLE;
      pend  <= 1'b0;
      found <= 1'b0;
      first <= 1'b1;
      cnt   <= '0;
    end else begin
      pend     <= (state == ccbl_pkg::ST_SCAN) && issue_ok;
      pend_idx <= cnt;
      unique case (state)
        ccbl_pkg::ST_IDLE: begin
          if (accept) begin
            mode_q    <= item.mode;
            four_q    <= four;
            cx        <= in_x;
            cy        <= in_y;
            cz        <= in_z;
            cw        <= in_w;
            span_q    <= span_in.mask;
            span_ok_q <= span_in.ok;
            val_q     <= val_ext[VALUE_WIDTH-1:0];
            cnt       <= '0;
            first     <= 1'b1;
            found     <= 1'b0;
            px        <= '0;
            py        <= '0;
            pz        <= '0;
            pw        <= '0;
            if ((item.mode == ccbl_pkg::MODE_PARENT) ||
                ((item.mode == ccbl_pkg::MODE_BIRTH) && span_in.ok))
              state <= ccbl_pkg::ST_SCAN;
            else
              state <= ccbl_pkg::ST_FINISH;
          end
        end
        ccbl_pkg::ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == last) state <= ccbl_pkg::ST_DRAIN;
        end
        ccbl_pkg::ST_DRAIN: begin
          state <= ccbl_pkg::ST_FINISH;
        end
        ccbl_pkg::ST_FINISH: begin
          if (!result.valid || result.ready) state <= ccbl_pkg::ST_IDLE;
        end
        default: state <= ccbl_pkg::ST_IDLE;
      endcase

      // Fold each returned voxel into the running answer.
      if (pend) begin
        if (mode_q == ccbl_pkg::MODE_BIRTH) begin
          if (first || hit_less) best <= $signed(rd_data);
          first <= 1'b0;
        end else if (!found && hit_equal) begin
          found <= 1'b1;
          px    <= poff[0] ? dec_wrap(cx) : cx;
          py    <= poff[1] ? dec_wrap(cy) : cy;
          pz    <= poff[2] ? dec_wrap(cz) : cz;
          pw    <= four_q ? (pend_idx[3] ? dec_wrap(cw) : cw) : '0;
        end
      end
    end
  end

  // Output register: hold the beat until the sink takes it.
  logic [VALUE_WIDTH+31:0] best_ext;
  logic signed [31:0]      birth_next;
  assign best_ext = {{32{best[VALUE_WIDTH-1]}}, best};

  always_comb begin
    birth_next = '0;
    if (mode_q == ccbl_pkg::MODE_BIRTH)
      birth_next = span_ok_q ? best_ext[31:0] : threshold_value;
  end

  wire load = (state == ccbl_pkg::ST_FINISH) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.birth_value  <= birth_next;
      result.parent_x     <= to_port(px);
      result.parent_y     <= to_port(py);
      result.parent_z     <= to_port(pz);
      result.parent_w     <= to_port(pw);
      result.parent_found <= found;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("new beat taken while item in flight");

  a_found_parent_only: assert property (@(posedge clk) disable iff (rst)
    found |-> mode_q == ccbl_pkg::MODE_PARENT)
    else $error("parent match flagged outside parent query");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ccbl_pkg::ST_SCAN || state == ccbl_pkg::ST_DRAIN))
    else $error("read return outside scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ccbl_pkg::ST_FINISH)
    else $error("result beat raised outside finish");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for cubical_cell_birth_lookup_top: random and directed
// voxel writes, birth and parent queries in 3D and 4D. Depends on ccbl_pkg,
// ccbl_if and the top-level RTL.
module testbench;

  // Allow for the slowest query with margin; any correct run finishes far sooner.
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // Spanned axes of a 2-cell by orientation (bit0 x .. bit3 w); 3D uses the first three.
  localparam logic [3:0] PLANE_SPANS [6] = '{4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC};
  // Parent search order on x, y, z: a set bit steps back one cube on that axis.
  localparam logic [2:0] PARENT_ORDER [8] = '{3'd0, 3'd1, 3'd3, 3'd7, 3'd5, 3'd2, 3'd6, 3'd4};
  // Cube coordinates that keep most queries on a small, reused patch of the grid.
  localparam logic [3:0] HOT_COORDS [4] = '{4'd14, 4'd15, 4'd0, 4'd1};

  typedef struct {
    ccbl_pkg::mode_t    mode;
    logic [3:0]         coord_x;
    logic [3:0]         coord_y;
    logic [3:0]         coord_z;
    logic [3:0]         coord_w;
    logic [2:0]         cell_dim;
    logic [2:0]         orientation;
    logic signed [31:0] data_value;
  } cell_req_t;

  typedef struct {
    logic signed [31:0] birth_value;
    logic [3:0]         parent_x;
    logic [3:0]         parent_y;
    logic [3:0]         parent_z;
    logic [3:0]         parent_w;
    logic               parent_found;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  ccbl_pkg::cfg_idx_t   cfg_index;
  logic [31:0]          cfg_data;

  ccbl_in_if  item_ch ();
  ccbl_out_if result_ch ();

  cubical_cell_birth_lookup_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Shadow of the block: configuration, voxel contents and which voxels hold data.
  logic [2:0]         grid_dims_q;
  logic signed [31:0] threshold_q;
  logic signed [31:0] voxel_mem [65536];
  bit                 voxel_known [65536];

  cell_result_t lookup_results_due [$];
  int           bad_fields = 0;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_requests   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Reference behavior
  // ---------------------------------------------------------------------------

  // Voxel address of a cube corner; a set corner bit means +1 on that axis.
  // In 3D the w axis is pinned to slice zero.
  function automatic logic [15:0] corner_addr(input logic [3:0] cx, cy, cz, cw,
                                              input logic [3:0] corner, input logic four);
    logic [3:0] ax, ay, az, aw;
    ax = cx + corner[0];
    ay = cy + corner[1];
    az = cz + corner[2];
    aw = four ? cw + corner[3] : 4'd0;
    return {aw, az, ay, ax};
  endfunction

  // Axes that a cell spans; returns 0 for a cell that does not exist.
  function automatic logic cell_span(input logic four, input logic [2:0] dim,
                                     input logic [2:0] orient, output logic [3:0] span);
    logic [2:0] top;
    top  = four ? 3'd4 : 3'd3;
    span = 4'h0;
    if (dim == 3'd0) return 1'b1;
    if (dim == top) begin
      span = four ? 4'hF : 4'h7;
      return 1'b1;
    end
    if (dim > top) return 1'b0;
    case (dim)
      3'd1: begin
        span = 4'h1 << orient;
        return orient < (four ? 3'd4 : 3'd3);
      end
      3'd2: begin
        if (orient >= (four ? 3'd6 : 3'd3)) return 1'b0;
        span = PLANE_SPANS[orient];
        return 1'b1;
      end
      default: begin
        // only a 4D grid gets here: a 3-cell leaves out one axis
        if (orient >= 3'd4) return 1'b0;
        span = 4'hF ^ (4'h8 >> orient);
        return 1'b1;
      end
    endcase
  endfunction

  // Work out the result of one accepted beat and update the shadow store.
  function automatic cell_result_t predict_cell_result(input cell_req_t r);
    cell_result_t       res;
    logic               four;
    logic [3:0]         span;
    logic [3:0]         corner;
    logic [3:0]         back;
    logic [15:0]        a;
    logic signed [31:0] v;
    res  = '{birth_value: '0, parent_x: '0, parent_y: '0, parent_z: '0,
             parent_w: '0, parent_found: 1'b0};
    four = grid_dims_q >= 3'd4;
    case (r.mode)
      ccbl_pkg::MODE_WRITE: begin
        a = corner_addr(r.coord_x, r.coord_y, r.coord_z, r.coord_w, 4'h0, four);
        voxel_mem[a]   = r.data_value;
        voxel_known[a] = 1'b1;
      end
      ccbl_pkg::MODE_BIRTH: begin
        res.birth_value = threshold_q;
        if (cell_span(four, r.cell_dim, r.orientation, span)) begin
          res.birth_value = 32'sh7FFFFFFF;
          for (int k = 0; k < 16; k++) begin
            corner = 4'(k);
            // every spanned axis sits at +1, the others at 0 or +1
            if ((corner & span) == span && (four || !corner[3])) begin
              v = voxel_mem[corner_addr(r.coord_x, r.coord_y, r.coord_z, r.coord_w,
                                        corner, four)];
              if (v < res.birth_value) res.birth_value = v;
            end
          end
        end
      end
      ccbl_pkg::MODE_PARENT: begin
        for (int k = 0; k < (four ? 16 : 8); k++) begin
          back = {(k >= 8) ? 1'b1 : 1'b0, PARENT_ORDER[k % 8]};
          a    = corner_addr(r.coord_x, r.coord_y, r.coord_z, r.coord_w, ~back, four);
          if (!res.parent_found && voxel_mem[a] == r.data_value) begin
            res.parent_found = 1'b1;
            res.parent_x     = r.coord_x - back[0];
            res.parent_y     = r.coord_y - back[1];
            res.parent_z     = r.coord_z - back[2];
            res.parent_w     = four ? r.coord_w - back[3] : 4'd0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Lean on the extremes and on a narrow band so that parent searches see ties.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:             return 32'sh7FFFFFFF;
      1:             return 32'sh80000000;
      2, 3, 4, 5:    return $signed($urandom_range(8)) - 32'sd4;
      default:       return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_axis();
    if ($urandom_range(99) < 80) return HOT_COORDS[$urandom_range(3)];
    return 4'($urandom_range(15));
  endfunction

  function automatic cell_req_t random_req(input ccbl_pkg::mode_t mode);
    cell_req_t r;
    r.mode        = mode;
    r.coord_x     = 4'($urandom_range(15));
    r.coord_y     = 4'($urandom_range(15));
    r.coord_z     = 4'($urandom_range(15));
    r.coord_w     = 4'($urandom_range(15));
    r.cell_dim    = 3'($urandom_range(7));
    r.orientation = 3'($urandom_range(7));
    r.data_value  = pick_value();
    return r;
  endfunction

  // Drive one beat and wait for it to be taken; the expected result is queued
  // at the edge that accepts it. Enter and leave just after a falling edge.
  task automatic send_beat(input cell_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.mode        <= r.mode;
    item_ch.coord_x     <= r.coord_x;
    item_ch.coord_y     <= r.coord_y;
    item_ch.coord_z     <= r.coord_z;
    item_ch.coord_w     <= r.coord_w;
    item_ch.cell_dim    <= r.cell_dim;
    item_ch.orientation <= r.orientation;
    item_ch.data_value  <= r.data_value;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    lookup_results_due.push_back(predict_cell_result(r));
    @(negedge clk);
  endtask

  // Drop valid and hold until every result is back, then let the block settle.
  task automatic wait_for_drain();
    item_ch.valid <= 1'b0;
    while (lookup_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Drive one register write for a cycle; the caller drops the write enable.
  task automatic write_register(input ccbl_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    if (idx == ccbl_pkg::CFG_GRID_DIMS) grid_dims_q = val[2:0];
    else                                threshold_q = val;
  endtask

  task automatic set_phase(input logic [2:0] dims, input logic [31:0] thr,
                           input int idle, input int stall);
    wait_for_drain();
    write_register(ccbl_pkg::CFG_GRID_DIMS, {29'd0, dims});
    write_register(ccbl_pkg::CFG_THRESHOLD, thr);
    cfg_we          <= 1'b0;
    sender_idle_pct = idle;
    stall_pct       = stall;
  endtask

  // Write every voxel around a cube that has never been written, so that a
  // query on it reads only loaded entries.
  task automatic fill_cube(input logic [3:0] cx, cy, cz, cw, output int n);
    cell_req_t   r;
    logic [15:0] a;
    logic        four;
    n    = 0;
    four = grid_dims_q >= 3'd4;
    for (int k = 0; k < 16; k++) begin
      a = corner_addr(cx, cy, cz, cw, 4'(k), four);
      if (!voxel_known[a]) begin
        r         = random_req(ccbl_pkg::MODE_WRITE);
        r.coord_x = a[3:0];
        r.coord_y = a[7:4];
        r.coord_z = a[11:8];
        if (four) r.coord_w = a[15:12];
        send_beat(r);
        n++;
      end
    end
  endtask

  function automatic cell_req_t query_req(input logic [3:0] cx, cy, cz, cw);
    cell_req_t r;
    logic      four;
    four          = grid_dims_q >= 3'd4;
    r             = random_req($urandom_range(99) < 55 ? ccbl_pkg::MODE_BIRTH
                                                       : ccbl_pkg::MODE_PARENT);
    r.coord_x     = cx;
    r.coord_y     = cy;
    r.coord_z     = cz;
    r.coord_w     = cw;
    r.cell_dim    = 3'(($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(7));
    r.orientation = 3'(($urandom_range(99) < 80) ? $urandom_range(5) : $urandom_range(7));
    // mostly search for a value that sits next to the cube
    if (r.mode == ccbl_pkg::MODE_PARENT && $urandom_range(99) < 70)
      r.data_value = voxel_mem[corner_addr(cx, cy, cz, cw, 4'($urandom_range(15)), four)];
    return r;
  endfunction

  // Mostly load-then-query sequences on a hot patch, with stray writes and
  // no-op beats mixed in. No-op beats do not count toward the target.
  task automatic run_traffic(input int target);
    int         sent;
    int         n;
    cell_req_t  r;
    logic [3:0] cx, cy, cz, cw;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(19))
        0, 1: begin
          r = random_req(ccbl_pkg::MODE_WRITE);
          send_beat(r);
          sent++;
        end
        2: begin
          r = random_req(ccbl_pkg::MODE_NONE);
          send_beat(r);
        end
        default: begin
          cx = pick_axis();
          cy = pick_axis();
          cz = pick_axis();
          cw = pick_axis();
          fill_cube(cx, cy, cz, cw, n);
          sent += n;
          repeat ($urandom_range(1, 3)) begin
            r = query_req(cx, cy, cz, cw);
            send_beat(r);
            sent++;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Load the cube at the far corner of a 3D grid with extreme values, then hit
  // every cell shape, both invalid-cell cases, found and missing parents and a
  // no-op beat. Corner voxels wrap from 15 to 0.
  task automatic test_directed_cases();
    logic signed [31:0] corner_vals [8];
    logic [2:0]         dims [11];
    logic [2:0]         orients [11];
    cell_req_t          r;
    corner_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1,
                    32'sd5, 32'sh00010000, -32'sd5, 32'sh7FFFFFFE};
    dims        = '{3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd7};
    orients     = '{3'd5, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd0, 3'd0};
    set_phase(3'd3, 32'h7FFFFFFF, 0, 0);
    for (int k = 0; k < 8; k++) begin
      r            = random_req(ccbl_pkg::MODE_WRITE);
      r.coord_x    = k[0] ? 4'd0 : 4'd15;
      r.coord_y    = k[1] ? 4'd0 : 4'd15;
      r.coord_z    = k[2] ? 4'd0 : 4'd15;
      r.coord_w    = 4'd9;  // ignored on a 3D grid
      r.data_value = corner_vals[k];
      send_beat(r);
    end
    for (int k = 0; k < 11; k++) begin
      r             = random_req(ccbl_pkg::MODE_BIRTH);
      r.coord_x     = 4'd15;
      r.coord_y     = 4'd15;
      r.coord_z     = 4'd15;
      r.cell_dim    = dims[k];
      r.orientation = orients[k];
      send_beat(r);
    end
    r            = random_req(ccbl_pkg::MODE_PARENT);
    r.coord_x    = 4'd15;
    r.coord_y    = 4'd15;
    r.coord_z    = 4'd15;
    r.data_value = corner_vals[6];
    send_beat(r);
    r.data_value = 32'sd12345;
    send_beat(r);
    r = random_req(ccbl_pkg::MODE_NONE);
    send_beat(r);
  endtask

  task automatic test_traffic_no_idle();
    set_phase(3'd4, 32'h80000000, 0, 0);
    run_traffic(350);
  endtask

  task automatic test_traffic_sender_idle();
    set_phase(3'd3, 32'h0, 88, 0);
    run_traffic(300);
  endtask

  task automatic test_traffic_receiver_stall();
    set_phase(3'd7, $urandom(), 0, 88);
    run_traffic(300);
  endtask

  task automatic test_traffic_both_idle();
    set_phase(3'd0, 32'h7FFFFFFF, 29, 29);
    run_traffic(300);
  endtask

  // Hold the result side off for a long stretch while beats keep coming, so
  // the block backs up and drops item ready.
  task automatic test_result_backpressure();
    set_phase(3'd4, $urandom(), 0, 0);
    hold_requests++;
    run_traffic(200);
  endtask

  // Pause the sender mid-stream until everything in flight has come back.
  task automatic test_sender_pause();
    set_phase(3'd4, 32'h7FFFFFFF, 29, 0);
    run_traffic(60);
    wait_for_drain();
    run_traffic(60);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready generation and checking
  // ---------------------------------------------------------------------------

  // Own the result ready: random stalls, plus a long hold each time a test asks.
  initial begin : result_ready_gen
    int hold_left;
    int hold_seen;
    hold_left       = 0;
    hold_seen       = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      bad_fields++;
    end
  endfunction

  // Compare every accepted result beat with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (lookup_results_due.size() == 0) begin
        $error("result beat with no outstanding request");
        bad_fields++;
      end else begin
        want = lookup_results_due.pop_front();
        check_field("birth_value", want.birth_value, result_ch.birth_value);
        check_field("parent_x", 32'(want.parent_x), 32'(result_ch.parent_x));
        check_field("parent_y", 32'(want.parent_y), 32'(result_ch.parent_y));
        check_field("parent_z", 32'(want.parent_z), 32'(result_ch.parent_z));
        check_field("parent_w", 32'(want.parent_w), 32'(result_ch.parent_w));
        check_field("parent_found", 32'(want.parent_found), 32'(result_ch.parent_found));
      end
    end
  end

  // End the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= ccbl_pkg::CFG_GRID_DIMS;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.mode        <= ccbl_pkg::MODE_NONE;
    item_ch.coord_x     <= '0;
    item_ch.coord_y     <= '0;
    item_ch.coord_z     <= '0;
    item_ch.coord_w     <= '0;
    item_ch.cell_dim    <= '0;
    item_ch.orientation <= '0;
    item_ch.data_value  <= '0;
    grid_dims_q         = 3'd3;
    threshold_q         = 32'sh7FFFFFFF;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_traffic_no_idle();
    test_traffic_sender_idle();
    test_traffic_receiver_stall();
    test_traffic_both_idle();
    test_result_backpressure();
    test_sender_pause();

    wait_for_drain();
    if (bad_fields == 0 && lookup_results_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
sv/ccbl_pkg.sv
sv/ccbl_if.sv
sv/cubical_cell_birth_lookup_top.sv
tb/testbench.sv
